[hdl/itrc_pkg.sv]
// ----------------------------------------------------------------------------
// itrc_pkg
// Shared types and constants of the IPv4 text range classifier.
// ----------------------------------------------------------------------------
package itrc_pkg;

	// Character codes used by the label parser
	localparam logic [7:0] CH_DOT  = 8'h2e;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_9    = 8'h39;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_A_LO = 8'h61;
	localparam logic [7:0] CH_F_LO = 8'h66;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_F_UP = 8'h46;

	// Label value saturates here; anything above 255 is malformed
	localparam logic [8:0] LABEL_SAT = 9'd256;
	localparam logic [8:0] OCTET_MAX = 9'd255;
	localparam logic [2:0] CNT_MAX   = 3'd7;
	localparam logic [2:0] LABELS    = 3'd4;

	// Depth of the queue between parser and classifier
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [3:0] {
		V_PUBLIC    = 4'd0,
		V_MALFORMED = 4'd1,
		V_ZERO_NET  = 4'd2,
		V_TEN_NET   = 4'd3,
		V_LOOPBACK  = 4'd4,
		V_LINK_LOC  = 4'd5,
		V_PRIV_172  = 4'd6,
		V_PRIV_192  = 4'd7,
		V_IETF_192  = 4'd8,
		V_CGNAT     = 4'd9,
		V_BENCH     = 4'd10,
		V_MCAST_RSV = 4'd11
	} verdict_t;

	// One parsed address text, handed from parser to classifier
	typedef struct packed {
		logic        bad;
		logic        canon;
		logic [31:0] addr;
	} text_rec_t;

endpackage

[hdl/itrc_if.sv]
// ----------------------------------------------------------------------------
// itrc_char_if / itrc_result_if
// Valid/ready channels for address characters and classification results.
// ----------------------------------------------------------------------------
interface itrc_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       has_char;
	logic       end_of_text;

	modport source (output valid, char_code, has_char, end_of_text, input ready);
	modport sink   (input valid, char_code, has_char, end_of_text, output ready);
endinterface

interface itrc_result_if;
	logic        valid;
	logic        ready;
	logic        blocked;
	logic [3:0]  verdict;
	logic        canonical;
	logic [31:0] address;

	modport source (output valid, blocked, verdict, canonical, address, input ready);
	modport sink   (input valid, blocked, verdict, canonical, address, output ready);
endinterface

[hdl/itrc_front.sv]
// ----------------------------------------------------------------------------
// itrc_front
// Character parser: accumulates labels and pushes one record per text.
// ----------------------------------------------------------------------------
module itrc_front
	import itrc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	itrc_char_if.sink          char_in,
	output logic               push_valid,
	input  logic               push_ready,
	output text_rec_t          push_data
);

	typedef struct packed {
		logic [8:0] value;
		logic [2:0] length;
		logic       lead_zero;
		logic       hex;
		logic [2:0] count;
		logic [7:0] oct1;
		logic [7:0] oct2;
		logic [7:0] oct3;
		logic       bad;
		logic       canon_bad;
	} parse_t;

	function automatic logic [8:0] sat_acc(logic [8:0] v, logic hex, logic [3:0] d);
		logic [12:0] n;
		n = hex ? {v, 4'b0000} : (({4'b0000, v} << 3) + ({4'b0000, v} << 1));
		n = n + {9'd0, d};
		return (n > {4'd0, LABEL_SAT}) ? LABEL_SAT : n[8:0];
	endfunction

	function automatic parse_t take_char(parse_t s, logic [7:0] c);
		parse_t r;
		logic   digit;
		r     = s;
		digit = (c >= CH_0) && (c <= CH_9);
		if (!digit) begin
			r.canon_bad = 1'b1;
		end
		if (s.length == 3'd1 && s.lead_zero && !s.hex && (c == CH_X_LO || c == CH_X_UP)) begin
			r.hex = 1'b1;
		end else if (s.hex) begin
			if (digit) begin
				r.value = sat_acc(s.value, 1'b1, c[3:0]);
			end else if (c >= CH_A_LO && c <= CH_F_LO) begin
				r.value = sat_acc(s.value, 1'b1, 4'(c - CH_A_LO + 8'd10));
			end else if (c >= CH_A_UP && c <= CH_F_UP) begin
				r.value = sat_acc(s.value, 1'b1, 4'(c - CH_A_UP + 8'd10));
			end else begin
				r.bad = 1'b1;
			end
		end else if (digit) begin
			if (s.length == 3'd0 && c == CH_0) begin
				r.lead_zero = 1'b1;
			end
			r.value = sat_acc(s.value, 1'b0, c[3:0]);
		end else begin
			r.bad = 1'b1;
		end
		if (s.length < CNT_MAX) begin
			r.length = s.length + 3'd1;
		end
		return r;
	endfunction

	function automatic parse_t close_label(parse_t s);
		parse_t r;
		r = s;
		if (s.hex && s.length == 3'd2) begin
			r.bad = 1'b1;
		end
		if (s.value > OCTET_MAX) begin
			r.bad = 1'b1;
		end
		if (s.count >= LABELS) begin
			r.bad       = 1'b1;
			r.canon_bad = 1'b1;
		end
		if (s.length == 3'd0 || s.length > 3'd3 || s.value > OCTET_MAX) begin
			r.canon_bad = 1'b1;
		end
		if (s.lead_zero && s.length > 3'd1) begin
			r.canon_bad = 1'b1;
		end
		case (s.count)
			3'd0:    r.oct1 = s.value[7:0];
			3'd1:    r.oct2 = s.value[7:0];
			3'd2:    r.oct3 = s.value[7:0];
			default: ;
		endcase
		if (s.count < CNT_MAX) begin
			r.count = s.count + 3'd1;
		end
		r.value     = '0;
		r.length    = '0;
		r.lead_zero = 1'b0;
		r.hex       = 1'b0;
		return r;
	endfunction

	parse_t state_q;
	parse_t after_char;
	parse_t after_end;
	logic   accept;

	// Only a closing transaction needs room in the queue
	assign char_in.ready = !char_in.end_of_text || push_ready;
	assign accept        = char_in.valid && char_in.ready;

	always_comb begin
		after_char = state_q;
		if (char_in.has_char) begin
			if (char_in.char_code == CH_DOT) begin
				after_char = close_label(state_q);
			end else begin
				after_char = take_char(state_q, char_in.char_code);
			end
		end
		after_end = close_label(after_char);
	end

	assign push_valid      = char_in.valid && char_in.end_of_text;
	assign push_data.bad   = after_end.bad || (after_end.count != LABELS);
	assign push_data.canon = !after_end.canon_bad;
	assign push_data.addr  = {after_end.oct1, after_end.oct2, after_end.oct3,
	                          after_char.value[7:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (accept) begin
			if (char_in.end_of_text) begin
				state_q <= '0;
			end else begin
				state_q <= after_char;
			end
		end
	end

endmodule

[hdl/itrc_queue.sv]
// ----------------------------------------------------------------------------
// itrc_queue
// Short FIFO of parsed text records between parser and classifier.
// ----------------------------------------------------------------------------
module itrc_queue
	import itrc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push_valid,
	output logic      push_ready,
	input  text_rec_t push_data,
	output logic      pop_valid,
	input  logic      pop_ready,
	output text_rec_t pop_data
);

	localparam logic [QUEUE_AW-1:0] LAST = QUEUE_AW'(QUEUE_DEPTH - 1);
	localparam logic [QUEUE_CW-1:0] FULL = QUEUE_CW'(QUEUE_DEPTH);

	text_rec_t             entry_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]   wr_ptr_q;
	logic [QUEUE_AW-1:0]   rd_ptr_q;
	logic [QUEUE_CW-1:0]   count_q;
	logic                  do_push;
	logic                  do_pop;

	assign push_ready = (count_q != FULL);
	assign pop_valid  = (count_q != '0);
	assign pop_data   = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + QUEUE_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QUEUE_CW'(1);
				2'b01:   count_q <= count_q - QUEUE_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hdl/itrc_back.sv]
// ----------------------------------------------------------------------------
// itrc_back
// Range classifier: matches the parsed address and holds the result register.
// ----------------------------------------------------------------------------
module itrc_back
	import itrc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        pop_valid,
	output logic        pop_ready,
	input  text_rec_t   pop_data,
	itrc_result_if.source result_out
);

	function automatic verdict_t classify(logic [7:0] a, logic [7:0] b, logic [7:0] c);
		verdict_t v;
		if (a == 8'd0) begin
			v = V_ZERO_NET;
		end else if (a == 8'd10) begin
			v = V_TEN_NET;
		end else if (a == 8'd127) begin
			v = V_LOOPBACK;
		end else if (a == 8'd169 && b == 8'd254) begin
			v = V_LINK_LOC;
		end else if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) begin
			v = V_PRIV_172;
		end else if (a == 8'd192 && b == 8'd168) begin
			v = V_PRIV_192;
		end else if (a == 8'd192 && b == 8'd0 && c == 8'd0) begin
			v = V_IETF_192;
		end else if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) begin
			v = V_CGNAT;
		end else if (a == 8'd198 && (b == 8'd18 || b == 8'd19)) begin
			v = V_BENCH;
		end else if (a >= 8'd224) begin
			v = V_MCAST_RSV;
		end else begin
			v = V_PUBLIC;
		end
		return v;
	endfunction

	logic        valid_q;
	verdict_t    verdict_q;
	logic        canon_q;
	logic [31:0] addr_q;
	verdict_t    verdict_d;

	assign pop_ready = !valid_q || result_out.ready;

	always_comb begin
		if (pop_data.bad) begin
			verdict_d = V_MALFORMED;
		end else begin
			verdict_d = classify(pop_data.addr[31:24], pop_data.addr[23:16],
			                     pop_data.addr[15:8]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop_ready) begin
			valid_q <= pop_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop_ready && pop_valid) begin
			verdict_q <= verdict_d;
			canon_q   <= pop_data.canon && !pop_data.bad;
			addr_q    <= pop_data.bad ? 32'd0 : pop_data.addr;
		end
	end

	assign result_out.valid     = valid_q;
	assign result_out.blocked   = (verdict_q != V_PUBLIC);
	assign result_out.verdict   = verdict_q;
	assign result_out.canonical = canon_q;
	assign result_out.address   = addr_q;

endmodule

[hdl/ipv4_text_range_classifier.sv]
// ----------------------------------------------------------------------------
// ipv4_text_range_classifier
// Parses IPv4 address text one byte per transaction and classifies the range.
// ----------------------------------------------------------------------------
// The block takes one character transaction per clock and gives one result
// transaction for each text, on the transaction that carries end_of_text.
// Labels are split on dots and read as decimal, or as hex after a 0x prefix;
// each byte only updates a small saturating accumulator, so the parser keeps
// one character per cycle. The result reaches result_out through the queue
// and the result register in turn: the parser pushes the finished record
// into a two-entry queue when the closing transaction is taken, and the
// classifier registers the verdict once the record is popped. A stalled
// result side does not hold up characters of the next text; only closing
// transactions wait, once the queue and the output register are both full.
// Send empty text as a single transaction with has_char low.
// ----------------------------------------------------------------------------
module ipv4_text_range_classifier
	import itrc_pkg::*;
(
	input  logic          clk,
	input  logic          arst_n,
	itrc_char_if.sink     char_in,
	itrc_result_if.source result_out
);

	// Parser to queue
	logic      push_valid;
	logic      push_ready;
	text_rec_t push_data;

	// Queue to classifier
	logic      pop_valid;
	logic      pop_ready;
	text_rec_t pop_data;

	// Front: accept characters, advance label state, emit a record at end of text
	itrc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.char_in    (char_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	// Queue: hold finished records so each side can stall on its own
	itrc_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data)
	);

	// Back: match special ranges and drive the result register
	itrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_data   (pop_data),
		.result_out (result_out)
	);

endmodule
